// ===== sv/tpt_pkg.sv =====
package tpt_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int DIST_W = 32;
  localparam int SPD_W  = 32;
  localparam int SQ_W   = 48;
  localparam int ACC_W  = 40;
  localparam int TIME_W = 48;

  // Divider geometry: every quotient is saturated to QUO_W bits
  localparam int QUO_W  = 48;
  localparam int DIV_W  = ACC_W + 1;
  localparam int SUM_W  = SPD_W + 1;
  localparam int LNUM_W = SQ_W + FRAC_BITS;
  localparam int TSH_W  = 2 * FRAC_BITS + 1;
  localparam int TNUM_W = QUO_W + TSH_W;
  localparam int WIDE_W = DIST_W + ACC_W;

  // Square root geometry
  localparam int RAD_W    = SQ_W + FRAC_BITS;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int RADP_W   = 2 * ROOT_W;
  localparam int SQREM_W  = ROOT_W + 1;
  localparam int ROOT_DLY = QUO_W - ROOT_W;

  localparam int LANES = 3;

  localparam logic [SQ_W-1:0]  SQ_MAX  = '1;
  localparam logic [SPD_W-1:0] SPD_MAX = '1;
  localparam logic [QUO_W-1:0] QUO_MAX = '1;

  // Action codes
  localparam logic ACT_PLAN   = 1'b0;
  localparam logic ACT_DIRECT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [DIST_W-1:0] distance;
    logic [SPD_W-1:0]  start_speed;
    logic [SPD_W-1:0]  end_speed;
    logic [SQ_W-1:0]   start_speed_sq;
    logic [SQ_W-1:0]   end_speed_sq;
    logic [SQ_W-1:0]   cruise_limit_sq;
    logic [ACC_W-1:0]  acceleration;
  } in_t;

  typedef struct packed {
    logic [SPD_W-1:0]  entry_speed;
    logic [SPD_W-1:0]  peak_speed;
    logic [SPD_W-1:0]  exit_speed;
    logic [TIME_W-1:0] ramp_up_time;
    logic [TIME_W-1:0] coast_time;
    logic [TIME_W-1:0] ramp_down_time;
    logic              bad_input;
  } out_t;

  // Sideband carried along the length/root chain
  typedef struct packed {
    logic [DIST_W-1:0] span;
    logic              bad;
    logic [1:0]        ovf;
  } side_a_t;

  // Sideband carried along the time chain
  typedef struct packed {
    logic [LANES-1:0][SPD_W-1:0] spd;
    logic                        bad;
    logic [LANES-1:0]            zero;
    logic [LANES-1:0]            ovf;
  } side_b_t;

endpackage

// ===== sv/trapezoid_profile_times.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//
// One item per cycle sustained unless a held result stalls the pipe; an item
// passes product stage, squares stage, 48 length cells (roots delayed to match),
// sum stage, 48 time cells, output register; 48-bit restoring divider cells set the depth.
// Reset clears only the valid bits and the skid register flag.
// A held result freezes the whole pipe; one more item is still taken into
// the input skid register, and in_stall_o rises only while that is full.
module trapezoid_profile_times import tpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic en, acc, src_v;
  in_t  src;

  assign en  = !out_valid_o || !out_stall_i;

  // Input skid register
  logic skid_v_q;
  in_t  skid_q;

  assign in_stall_o = skid_v_q;
  assign acc        = in_valid_i && !skid_v_q;
  assign src_v      = skid_v_q || acc;
  assign src        = skid_v_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && acc) begin
      skid_q <= in_data_i;
    end
  end

  // Stage 1: products
  logic                  s1_v_q;
  in_t                   s1_in_q;
  logic [2*SPD_W-1:0]    s1_ss_q, s1_ee_q;
  logic [WIDE_W-1:0]     s1_da_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= src_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_in_q <= src;
      s1_ss_q <= src.start_speed * src.start_speed;
      s1_ee_q <= src.end_speed * src.end_speed;
      s1_da_q <= src.distance * src.acceleration;
    end
  end

  // Stage 2: squared speeds, peak cap, entry/exit cap
  logic [2*SPD_W-1:0] ss_sh, ee_sh;
  logic [WIDE_W-1:0]  da_sh;
  logic [SQ_W-1:0]    sv2_p, ev2_p, da_p, half_p, cv2_p;
  logic [SQ_W:0]      pair, sum_p;
  logic [SQ_W-1:0]    sv2_d, ev2_d, cv2_d;

  always_comb begin
    ss_sh  = s1_ss_q >> FRAC_BITS;
    ee_sh  = s1_ee_q >> FRAC_BITS;
    da_sh  = s1_da_q >> FRAC_BITS;
    sv2_p  = (WIDE_W'(ss_sh) > WIDE_W'(SQ_MAX)) ? SQ_MAX : SQ_W'(ss_sh);
    ev2_p  = (WIDE_W'(ee_sh) > WIDE_W'(SQ_MAX)) ? SQ_MAX : SQ_W'(ee_sh);
    da_p   = (da_sh > WIDE_W'(SQ_MAX)) ? SQ_MAX : SQ_W'(da_sh);
    pair   = {1'b0, sv2_p} + {1'b0, ev2_p};
    half_p = pair[SQ_W:1];
    sum_p  = {1'b0, da_p} + {1'b0, half_p};
    cv2_p  = sum_p[SQ_W] ? SQ_MAX : sum_p[SQ_W-1:0];
    if (cv2_p > s1_in_q.cruise_limit_sq) begin
      cv2_p = s1_in_q.cruise_limit_sq;
    end
    if (s1_in_q.action == ACT_DIRECT) begin
      sv2_d = s1_in_q.start_speed_sq;
      ev2_d = s1_in_q.end_speed_sq;
      cv2_d = s1_in_q.cruise_limit_sq;
    end else begin
      sv2_d = sv2_p;
      ev2_d = ev2_p;
      cv2_d = cv2_p;
    end
    if (sv2_d > cv2_d) begin
      sv2_d = cv2_d;
    end
    if (ev2_d > cv2_d) begin
      ev2_d = cv2_d;
    end
  end

  logic              s2_v_q, s2_bad_q;
  logic [DIST_W-1:0] s2_dist_q;
  logic [DIV_W-1:0]  s2_twoa_q;
  logic [SQ_W-1:0]   s2_sq_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_bad_q   <= (s1_in_q.acceleration == '0);
      s2_dist_q  <= s1_in_q.distance;
      s2_twoa_q  <= {s1_in_q.acceleration, 1'b0};
      s2_sq_q[0] <= sv2_d;
      s2_sq_q[1] <= cv2_d;
      s2_sq_q[2] <= ev2_d;
    end
  end

  // Chain A: ramp lengths (two divider lanes) and speeds (three root lanes)
  logic [DIV_W-1:0]   la_den [2][QUO_W+1];
  logic [DIV_W-1:0]   la_rem [2][QUO_W+1];
  logic [QUO_W-1:0]   la_num [2][QUO_W+1];
  logic [QUO_W-1:0]   la_quo [2][QUO_W+1];
  logic [1:0]         la_ovf;
  logic [RADP_W-1:0]  sr_rad  [LANES][ROOT_W+1];
  logic [SQREM_W-1:0] sr_rem  [LANES][ROOT_W+1];
  logic [ROOT_W-1:0]  sr_root [LANES][ROOT_W+1];

  for (genvar l = 0; l < 2; l++) begin : g_len
    logic [SQ_W-1:0]      diff;
    logic [LNUM_W-1:0]    lnum;
    logic [FRAC_BITS-1:0] top;

    // up uses entry square, down uses exit square
    assign diff = s2_sq_q[1] - s2_sq_q[2*l];
    assign lnum = {diff, {FRAC_BITS{1'b0}}};
    assign top  = lnum[LNUM_W-1:QUO_W];
    assign la_ovf[l]    = DIV_W'(top) >= s2_twoa_q;
    assign la_den[l][0] = s2_twoa_q;
    assign la_rem[l][0] = DIV_W'(top);
    assign la_num[l][0] = lnum[QUO_W-1:0];
    assign la_quo[l][0] = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      tpt_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .den_i (la_den[l][k]),
        .rem_i (la_rem[l][k]),
        .num_i (la_num[l][k]),
        .quo_i (la_quo[l][k]),
        .den_o (la_den[l][k+1]),
        .rem_o (la_rem[l][k+1]),
        .num_o (la_num[l][k+1]),
        .quo_o (la_quo[l][k+1])
      );
    end
  end

  logic [ROOT_W-1:0] rdly_q [LANES][ROOT_DLY];

  for (genvar l = 0; l < LANES; l++) begin : g_root
    assign sr_rad[l][0]  = RADP_W'({s2_sq_q[l], {FRAC_BITS{1'b0}}});
    assign sr_rem[l][0]  = '0;
    assign sr_root[l][0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
      tpt_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rad_i  (sr_rad[l][k]),
        .rem_i  (sr_rem[l][k]),
        .root_i (sr_root[l][k]),
        .rad_o  (sr_rad[l][k+1]),
        .rem_o  (sr_rem[l][k+1]),
        .root_o (sr_root[l][k+1])
      );
    end

    // Roots finish early; hold them until the lengths catch up
    always_ff @(posedge clk_i) begin
      if (en) begin
        rdly_q[l][0] <= sr_root[l][ROOT_W];
        for (int k = 1; k < ROOT_DLY; k++) begin
          rdly_q[l][k] <= rdly_q[l][k-1];
        end
      end
    end
  end

  logic [QUO_W-1:0] va_q;
  side_a_t          sa_q [QUO_W];
  side_a_t          sa_in;

  assign sa_in = '{span: s2_dist_q, bad: s2_bad_q, ovf: la_ovf};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else if (en) begin
      va_q <= {va_q[QUO_W-2:0], s2_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= sa_in;
      for (int k = 1; k < QUO_W; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
    end
  end

  // Stage 3: coast length, speed saturation, mean-speed sums
  side_a_t           sa_end;
  logic [QUO_W-1:0]  up_len, dn_len, dist_w;
  logic [DIST_W-1:0] coast_len;
  logic [SPD_W-1:0]  spd [LANES];
  logic [ROOT_W-1:0] root_end [LANES];

  assign sa_end = sa_q[QUO_W-1];

  always_comb begin
    up_len    = sa_end.ovf[0] ? QUO_MAX : la_quo[0][QUO_W];
    dn_len    = sa_end.ovf[1] ? QUO_MAX : la_quo[1][QUO_W];
    dist_w    = QUO_W'(sa_end.span);
    coast_len = '0;
    if (up_len < dist_w && dn_len < dist_w - up_len) begin
      coast_len = DIST_W'(dist_w - up_len - dn_len);
    end
    for (int l = 0; l < LANES; l++) begin
      root_end[l] = rdly_q[l][ROOT_DLY-1];
      spd[l] = (WIDE_W'(root_end[l]) > WIDE_W'(SPD_MAX)) ? SPD_MAX : SPD_W'(root_end[l]);
    end
  end

  logic             s3_v_q, s3_bad_q;
  logic [SPD_W-1:0] s3_spd_q [LANES];
  logic [QUO_W-1:0] s3_len_q [LANES];
  logic [SUM_W-1:0] s3_den_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= va_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_bad_q    <= sa_end.bad;
      s3_spd_q[0] <= spd[0];
      s3_spd_q[1] <= spd[1];
      s3_spd_q[2] <= spd[2];
      s3_len_q[0] <= up_len;
      s3_len_q[1] <= QUO_W'(coast_len);
      s3_len_q[2] <= dn_len;
      s3_den_q[0] <= {1'b0, spd[0]} + {1'b0, spd[1]};
      s3_den_q[1] <= {1'b0, spd[1]};
      s3_den_q[2] <= {1'b0, spd[2]} + {1'b0, spd[1]};
    end
  end

  // Chain B: phase times, lanes up, coast, down
  logic [DIV_W-1:0] tb_den [LANES][QUO_W+1];
  logic [DIV_W-1:0] tb_rem [LANES][QUO_W+1];
  logic [QUO_W-1:0] tb_num [LANES][QUO_W+1];
  logic [QUO_W-1:0] tb_quo [LANES][QUO_W+1];
  logic [LANES-1:0] tb_ovf, tb_zero;

  for (genvar l = 0; l < LANES; l++) begin : g_time
    logic [TNUM_W-1:0] tnum;
    logic [TSH_W-1:0]  top;

    // ramps divide by the speed sum, so they carry one extra shift
    if (l == 1) begin : g_coast
      assign tnum = {1'b0, s3_len_q[l], {(TSH_W-1){1'b0}}};
    end else begin : g_ramp
      assign tnum = {s3_len_q[l], {TSH_W{1'b0}}};
    end
    assign top          = tnum[TNUM_W-1:QUO_W];
    assign tb_ovf[l]    = WIDE_W'(top) >= WIDE_W'(s3_den_q[l]);
    assign tb_zero[l]   = (s3_len_q[l] == '0);
    assign tb_den[l][0] = DIV_W'(s3_den_q[l]);
    assign tb_rem[l][0] = DIV_W'(top);
    assign tb_num[l][0] = tnum[QUO_W-1:0];
    assign tb_quo[l][0] = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      tpt_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .den_i (tb_den[l][k]),
        .rem_i (tb_rem[l][k]),
        .num_i (tb_num[l][k]),
        .quo_i (tb_quo[l][k]),
        .den_o (tb_den[l][k+1]),
        .rem_o (tb_rem[l][k+1]),
        .num_o (tb_num[l][k+1]),
        .quo_o (tb_quo[l][k+1])
      );
    end
  end

  logic [QUO_W-1:0] vb_q;
  side_b_t          sb_q [QUO_W];
  side_b_t          sb_in;

  always_comb begin
    sb_in.spd[0] = s3_spd_q[0];
    sb_in.spd[1] = s3_spd_q[1];
    sb_in.spd[2] = s3_spd_q[2];
    sb_in.bad    = s3_bad_q;
    sb_in.zero   = tb_zero;
    sb_in.ovf    = tb_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (en) begin
      vb_q <= {vb_q[QUO_W-2:0], s3_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_in;
      for (int k = 1; k < QUO_W; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // Output register: zero/saturate the times
  side_b_t           sb_end;
  logic [TIME_W-1:0] tm [LANES];
  out_t              out_d, out_q;
  logic              out_v_q;

  assign sb_end = sb_q[QUO_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (sb_end.bad || sb_end.zero[l]) begin
        tm[l] = '0;
      end else if (sb_end.ovf[l]) begin
        tm[l] = QUO_MAX;
      end else begin
        tm[l] = tb_quo[l][QUO_W];
      end
    end
    out_d.entry_speed    = sb_end.spd[0];
    out_d.peak_speed     = sb_end.spd[1];
    out_d.exit_speed     = sb_end.spd[2];
    out_d.ramp_up_time   = tm[0];
    out_d.coast_time     = tm[1];
    out_d.ramp_down_time = tm[2];
    out_d.bad_input      = sb_end.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vb_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/tpt_div_cell.sv =====
module tpt_div_cell import tpt_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] den_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [QUO_W-1:0] num_i,
  input  logic [QUO_W-1:0] quo_i,
  output logic [DIV_W-1:0] den_o,
  output logic [DIV_W-1:0] rem_o,
  output logic [QUO_W-1:0] num_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W:0]   trial;
  logic             take;
  logic [DIV_W-1:0] den_q, rem_q, rem_d;
  logic [QUO_W-1:0] num_q, quo_q;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, num_i[QUO_W-1]};
    take  = trial >= {1'b0, den_i};
    rem_d = take ? DIV_W'(trial - {1'b0, den_i}) : DIV_W'(trial);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rem_q <= rem_d;
      num_q <= {num_i[QUO_W-2:0], 1'b0};
      quo_q <= {quo_i[QUO_W-2:0], take};
    end
  end

  assign den_o = den_q;
  assign rem_o = rem_q;
  assign num_o = num_q;
  assign quo_o = quo_q;

endmodule

// ===== sv/tpt_sqrt_cell.sv =====
module tpt_sqrt_cell import tpt_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [RADP_W-1:0]  rad_i,
  input  logic [SQREM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0]  root_i,
  output logic [RADP_W-1:0]  rad_o,
  output logic [SQREM_W-1:0] rem_o,
  output logic [ROOT_W-1:0]  root_o
);

  logic [SQREM_W+1:0] cur, trial;
  logic               take;
  logic [SQREM_W-1:0] rem_d, rem_q;
  logic [RADP_W-1:0]  rad_q;
  logic [ROOT_W-1:0]  root_q;

  // One root bit: bring down two radicand bits, try (4r + 1)
  always_comb begin
    cur   = {rem_i, rad_i[RADP_W-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    take  = cur >= trial;
    rem_d = take ? SQREM_W'(cur - trial) : SQREM_W'(cur);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[RADP_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_i[ROOT_W-2:0], take};
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
